// ----- design/lfc_pkg.sv -----
// lfc_pkg: shared types, constants and tables of the led fade controller
package lfc_pkg;

   localparam int CMD_W     = 3;
   localparam int PERCENT_W = 7;
   localparam int FADE_W    = 16;
   localparam int NOW_W     = 32;
   localparam int LEVEL_W   = 8;

   localparam int SINE_STEPS_DEFAULT = 256;
   localparam int TIME_BITS_DEFAULT  = 32;

   // pi/2 in q30
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [63:0] Q30_HALF    = 64'd536870912;

   localparam logic [LEVEL_W-1:0] LEVEL_FULL = 8'd255;
   localparam logic [LEVEL_W-1:0] LEVEL_ZERO = 8'd0;

   typedef enum logic [CMD_W-1:0] {
      CMD_ON      = 3'd0,
      CMD_ON_PCT  = 3'd1,
      CMD_OFF     = 3'd2,
      CMD_TOGGLE  = 3'd3,
      CMD_LIN_IN  = 3'd4,
      CMD_LIN_OUT = 3'd5,
      CMD_SINE_IN = 3'd6,
      CMD_STATUS  = 3'd7
   } cmd_type;

   typedef logic [LEVEL_W-1:0] pct_table_type [2**PERCENT_W];

   // percent 1..100 maps linearly onto 1..255, above 100 clamps
   function automatic pct_table_type build_pct_table();
      pct_table_type t;
      int pp;
      for (int p = 0; p < 2**PERCENT_W; p++) begin
         pp = (p > 100) ? 100 : p;
         if (p == 0) begin
            t[p] = LEVEL_ZERO;
         end else begin
            t[p] = LEVEL_W'((pp - 1) * 254 / 99 + 1);
         end
      end
      return t;
   endfunction

   localparam pct_table_type PCT_LEVEL = build_pct_table();

endpackage

// ----- design/lfc_channels.sv -----
// lfc_channels: valid/ready channel interfaces for command and result beats

interface lfc_req_if;
   logic                           valid;
   logic                           ready;
   logic [lfc_pkg::CMD_W-1:0]      cmd;
   logic [lfc_pkg::PERCENT_W-1:0]  percent;
   logic [lfc_pkg::FADE_W-1:0]     fade_ms;
   logic [lfc_pkg::NOW_W-1:0]      now_ms;

   modport source (output valid, cmd, percent, fade_ms, now_ms, input ready);
   modport sink   (input valid, cmd, percent, fade_ms, now_ms, output ready);
endinterface

interface lfc_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [lfc_pkg::LEVEL_W-1:0]    pwm_level;
   logic                           led_on;
   logic                           fade_active;

   modport source (output valid, pwm_level, led_on, fade_active, input ready);
   modport sink   (input valid, pwm_level, led_on, fade_active, output ready);
endinterface

// ----- design/led_fade_controller_unit.sv -----
// led_fade_controller_unit: led brightness, on/off and fade sequencer
//
//   channel    dir   handshake          payload
//   req_chan   in    valid/ready beat   cmd, percent, fade_ms, now_ms
//   rsp_chan   out   valid/ready beat   pwm_level, led_on, fade_active
//
// plain commands and fade starts go from accept straight to S_WRITE, which registers the result
// a fade advance runs S_SUB, S_PREP1, S_PREP2, S_DIV, S_ROM, then S_WRITE: the
//   elapsed time is subtracted one bit a cycle, then a restoring divider
//   produces one quotient bit a cycle, then the sine rom is read
// synchronous reset clears level, on state, fade flag, start time and span
// a new command is taken while the previous result still waits in rsp_chan
module led_fade_controller_unit #(
   parameter int SINE_STEPS = lfc_pkg::SINE_STEPS_DEFAULT,
   parameter int TIME_BITS  = lfc_pkg::TIME_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   lfc_req_if.sink     req_chan,
   lfc_rsp_if.source   rsp_chan
);

   localparam int TW    = TIME_BITS;
   localparam int IW    = $clog2(SINE_STEPS);
   localparam int QUO_W = (IW > 8) ? IW : 8;
   localparam int FW    = lfc_pkg::FADE_W;
   localparam int NW    = FW + QUO_W;
   localparam int CW    = $clog2((TW > QUO_W) ? TW : QUO_W);
   localparam int LW    = lfc_pkg::LEVEL_W;

   typedef logic [LW-1:0] sine_rom_type [SINE_STEPS];

   function automatic logic [LW-1:0] sine_entry(input int idx);
      logic [63:0] theta;
      logic [63:0] theta2;
      logic [63:0] term;
      logic [63:0] v;
      longint      sum;
      theta  = (lfc_pkg::HALF_PI_Q30 * 64'(idx)) / 64'(SINE_STEPS - 1);
      theta2 = (theta * theta) >> 30;
      sum    = longint'(theta);
      term   = ((theta * theta2) >> 30) / 64'd6;
      sum    = sum - longint'(term);
      term   = ((term * theta2) >> 30) / 64'd20;
      sum    = sum + longint'(term);
      term   = ((term * theta2) >> 30) / 64'd42;
      sum    = sum - longint'(term);
      term   = ((term * theta2) >> 30) / 64'd72;
      sum    = sum + longint'(term);
      if (sum < 0) begin
         sum = 0;
      end
      v = (64'(sum) * 64'd255 + lfc_pkg::Q30_HALF) >> 30;
      return (v > 64'd255) ? lfc_pkg::LEVEL_FULL : v[LW-1:0];
   endfunction

   function automatic sine_rom_type build_sine_rom();
      sine_rom_type t;
      for (int i = 0; i < SINE_STEPS; i++) begin
         t[i] = sine_entry(i);
      end
      return t;
   endfunction

   localparam sine_rom_type SINE_ROM = build_sine_rom();

   typedef enum logic [2:0] {
      S_IDLE,
      S_SUB,
      S_PREP1,
      S_PREP2,
      S_DIV,
      S_ROM,
      S_WRITE
   } state_type;

   state_type                     state_ff, state_in;
   lfc_pkg::cmd_type              cmd_ff, cmd_in;
   logic [lfc_pkg::PERCENT_W-1:0] pct_ff, pct_in;
   logic [FW-1:0]                 dur_ff, dur_in;
   logic [TW-1:0]                 now_ff, now_in;
   logic [TW-1:0]                 sub_b_ff, sub_b_in;
   logic                          borrow_ff, borrow_in;
   logic [TW-1:0]                 elapsed_ff, elapsed_in;
   logic [CW-1:0]                 cnt_ff, cnt_in;
   logic [TW+7:0]                 wide_ff, wide_in;
   logic [FW-1:0]                 tmin_ff, tmin_in;
   logic                          ovf_ff, ovf_in;
   logic [FW-1:0]                 rem_ff, rem_in;
   logic [QUO_W-1:0]              quo_ff, quo_in;
   logic [LW-1:0]                 rom_ff, rom_in;

   logic [LW-1:0]                 level_ff, level_in;
   logic                          is_on_ff, is_on_in;
   logic                          in_fade_ff, in_fade_in;
   logic [TW-1:0]                 start_ff, start_in;
   logic [FW-1:0]                 span_ff, span_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [LW-1:0]                 rsp_level_ff, rsp_level_in;
   logic                          rsp_on_ff, rsp_on_in;
   logic                          rsp_fade_ff, rsp_fade_in;

   logic                          diff_bit;
   logic [NW-1:0]                 num;
   logic [FW:0]                   trial;
   logic [FW:0]                   trial_diff;
   logic                          trial_ge;
   logic [IW-1:0]                 rom_addr;
   logic [LW-1:0]                 ramp;
   logic                          is_fade_cmd;

   assign req_chan.ready        = (state_ff == S_IDLE);
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.pwm_level    = rsp_level_ff;
   assign rsp_chan.led_on       = rsp_on_ff;
   assign rsp_chan.fade_active  = rsp_fade_ff;

   assign is_fade_cmd = (req_chan.cmd == lfc_pkg::CMD_LIN_IN)
                     || (req_chan.cmd == lfc_pkg::CMD_LIN_OUT)
                     || (req_chan.cmd == lfc_pkg::CMD_SINE_IN);

   // one bit of now - start_time, lsb first
   assign diff_bit = now_ff[0] ^ sub_b_ff[0] ^ borrow_ff;

   assign num = (cmd_ff == lfc_pkg::CMD_SINE_IN)
              ? NW'(tmin_ff) * NW'(SINE_STEPS - 1)
              : NW'(wide_ff);

   assign trial      = {rem_ff, quo_ff[QUO_W-1]};
   assign trial_ge   = (trial >= {1'b0, span_ff});
   assign trial_diff = trial - {1'b0, span_ff};

   assign rom_addr = (span_ff == '0) ? IW'(SINE_STEPS - 1) : quo_ff[IW-1:0];
   // a zero span always overflows, which gives full scale
   assign ramp     = ovf_ff ? lfc_pkg::LEVEL_FULL : quo_ff[LW-1:0];

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      pct_in       = pct_ff;
      dur_in       = dur_ff;
      now_in       = now_ff;
      sub_b_in     = sub_b_ff;
      borrow_in    = borrow_ff;
      elapsed_in   = elapsed_ff;
      cnt_in       = cnt_ff;
      wide_in      = wide_ff;
      tmin_in      = tmin_ff;
      ovf_in       = ovf_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      rom_in       = rom_ff;
      level_in     = level_ff;
      is_on_in     = is_on_ff;
      in_fade_in   = in_fade_ff;
      start_in     = start_ff;
      span_in      = span_ff;
      rsp_level_in = rsp_level_ff;
      rsp_on_in    = rsp_on_ff;
      rsp_fade_in  = rsp_fade_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;

      unique case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               cmd_in    = lfc_pkg::cmd_type'(req_chan.cmd);
               pct_in    = req_chan.percent;
               dur_in    = req_chan.fade_ms;
               now_in    = req_chan.now_ms[TW-1:0];
               sub_b_in  = start_ff;
               borrow_in = 1'b0;
               cnt_in    = '0;
               state_in  = (in_fade_ff && is_fade_cmd) ? S_SUB : S_WRITE;
            end
         end
         S_SUB: begin
            now_in     = {1'b0, now_ff[TW-1:1]};
            sub_b_in   = {1'b0, sub_b_ff[TW-1:1]};
            borrow_in  = (!now_ff[0] && sub_b_ff[0]) || (!now_ff[0] && borrow_ff)
                      || (sub_b_ff[0] && borrow_ff);
            elapsed_in = {diff_bit, elapsed_ff[TW-1:1]};
            cnt_in     = cnt_ff + 1'b1;
            if (cnt_ff == CW'(TW - 1)) begin
               state_in = S_PREP1;
            end
         end
         S_PREP1: begin
            // 255 * e as (e << 8) - e
            wide_in  = {elapsed_ff, 8'd0} - {8'd0, elapsed_ff};
            tmin_in  = (elapsed_ff < TW'(span_ff)) ? elapsed_ff[FW-1:0] : span_ff;
            state_in = S_PREP2;
         end
         S_PREP2: begin
            ovf_in   = (wide_ff[TW+7:8] >= TW'(span_ff));
            rem_in   = num[NW-1:QUO_W];
            quo_in   = num[QUO_W-1:0];
            cnt_in   = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            rem_in = trial_ge ? trial_diff[FW-1:0] : trial[FW-1:0];
            quo_in = {quo_ff[QUO_W-2:0], trial_ge};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CW'(QUO_W - 1)) begin
               state_in = S_ROM;
            end
         end
         S_ROM: begin
            rom_in   = SINE_ROM[rom_addr];
            state_in = S_WRITE;
         end
         S_WRITE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               case (cmd_ff)
                  lfc_pkg::CMD_ON: begin
                     level_in = lfc_pkg::LEVEL_FULL;
                     is_on_in = 1'b1;
                  end
                  lfc_pkg::CMD_ON_PCT: begin
                     level_in = lfc_pkg::PCT_LEVEL[pct_ff];
                     is_on_in = (pct_ff != '0);
                  end
                  lfc_pkg::CMD_OFF: begin
                     level_in = lfc_pkg::LEVEL_ZERO;
                     is_on_in = 1'b0;
                  end
                  lfc_pkg::CMD_TOGGLE: begin
                     level_in = is_on_ff ? lfc_pkg::LEVEL_ZERO : lfc_pkg::LEVEL_FULL;
                     is_on_in = !is_on_ff;
                  end
                  lfc_pkg::CMD_LIN_IN, lfc_pkg::CMD_SINE_IN: begin
                     if (in_fade_ff) begin
                        if (level_ff != lfc_pkg::LEVEL_FULL) begin
                           level_in = (cmd_ff == lfc_pkg::CMD_SINE_IN) ? rom_ff : ramp;
                        end else begin
                           in_fade_in = 1'b0;
                           level_in   = lfc_pkg::LEVEL_FULL;
                           is_on_in   = 1'b1;
                        end
                     end else if (!is_on_ff) begin
                        span_in    = dur_ff;
                        start_in   = now_ff;
                        level_in   = lfc_pkg::LEVEL_ZERO;
                        in_fade_in = 1'b1;
                     end
                  end
                  lfc_pkg::CMD_LIN_OUT: begin
                     if (in_fade_ff) begin
                        if (level_ff != lfc_pkg::LEVEL_ZERO) begin
                           level_in = ~ramp;
                        end else begin
                           in_fade_in = 1'b0;
                           level_in   = lfc_pkg::LEVEL_ZERO;
                           is_on_in   = 1'b0;
                        end
                     end else if (is_on_ff) begin
                        span_in    = dur_ff;
                        start_in   = now_ff;
                        level_in   = lfc_pkg::LEVEL_FULL;
                        in_fade_in = 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
               rsp_level_in = level_in;
               rsp_on_in    = is_on_in;
               rsp_fade_in  = in_fade_in;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         level_ff     <= '0;
         is_on_ff     <= 1'b0;
         in_fade_ff   <= 1'b0;
         start_ff     <= '0;
         span_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         level_ff     <= level_in;
         is_on_ff     <= is_on_in;
         in_fade_ff   <= in_fade_in;
         start_ff     <= start_in;
         span_ff      <= span_in;
      end
      cmd_ff       <= cmd_in;
      pct_ff       <= pct_in;
      dur_ff       <= dur_in;
      now_ff       <= now_in;
      sub_b_ff     <= sub_b_in;
      borrow_ff    <= borrow_in;
      elapsed_ff   <= elapsed_in;
      cnt_ff       <= cnt_in;
      wide_ff      <= wide_in;
      tmin_ff      <= tmin_in;
      ovf_ff       <= ovf_in;
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      rom_ff       <= rom_in;
      rsp_level_ff <= rsp_level_in;
      rsp_on_ff    <= rsp_on_in;
      rsp_fade_ff  <= rsp_fade_in;
   end

endmodule

// ----- design/lfc_checker.sv -----
// lfc_checker: port-level assertions for the led fade controller, and its bind
module lfc_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [lfc_pkg::LEVEL_W-1:0]  pwm_level,
   input logic                         led_on,
   input logic                         fade_active
);

   // one command at a time: ready drops after every accepted beat
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req_ready stayed high after an accepted beat");

   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result beat dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         $stable(pwm_level) && $stable(led_on) && $stable(fade_active))
      else $error("result payload changed while stalled");

   // outside a fade, off means dark
   a_off_dark: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !fade_active && !led_on |-> pwm_level == '0)
      else $error("led off outside a fade with nonzero level");

   // outside a fade, on means lit
   a_on_lit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !fade_active && led_on |-> pwm_level != '0)
      else $error("led on outside a fade with zero level");

endmodule

bind led_fade_controller_unit lfc_checker u_lfc_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .pwm_level   (rsp_chan.pwm_level),
   .led_on      (rsp_chan.led_on),
   .fade_active (rsp_chan.fade_active)
);
